// ----- rtl/ubd_pkg.sv -----
// Shared types and constants for the UTF-8 byte stream decoder.
package ubd_pkg;

    localparam int CP_W           = 21;
    localparam int TDATA_IN_W     = 8;
    localparam int TDATA_OUT_W    = 24;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

    localparam logic [7:0] BYTE_LEAD2   = 8'hC2;
    localparam logic [7:0] BYTE_LEAD3   = 8'hE0;
    localparam logic [7:0] BYTE_LEAD4   = 8'hF0;
    localparam logic [7:0] BYTE_CONT_MK = 8'hC0;
    localparam logic [7:0] BYTE_CONT    = 8'h80;
    localparam logic [7:0] MASK_CONT    = 8'h3F;
    localparam logic [7:0] MASK_LEAD2   = 8'h1F;
    localparam logic [7:0] MASK_LEAD3   = 8'h0F;
    localparam logic [7:0] MASK_LEAD4   = 8'h07;

    // One result item
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            end_of_text;
        logic            last_of_run;
    } result_t;

    // Results caused by one input byte: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } dec_out_t;

endpackage

// ----- rtl/ubd_decode.sv -----
// Sequence state and combinational decode of one byte into up to two results.
module ubd_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        byte_in,
    output ubd_pkg::dec_out_t dec
);
    import ubd_pkg::*;

    logic [CP_W-1:0] partial_reg, partial_next;
    logic [1:0]      remain_reg, remain_next;

    logic            is_cont;
    logic            pending;
    logic [CP_W-1:0] cont_bits;
    logic [CP_W-1:0] merged;
    logic            own_valid;
    logic [CP_W-1:0] own_cp;
    logic            own_eot;

    // Decode the byte against the pending sequence
    always_comb
    begin
        pending      = (remain_reg != 2'd0);
        is_cont      = pending && ((byte_in & BYTE_CONT_MK) == BYTE_CONT);
        partial_next = partial_reg;
        remain_next  = remain_reg;
        own_valid    = 1'b0;
        own_cp       = '0;
        own_eot      = 1'b0;
        dec          = '0;

        // Place continuation bits by how many bytes are still expected
        case (remain_reg)
            2'd3:    cont_bits = {3'b0, byte_in[5:0], 12'b0};
            2'd2:    cont_bits = {9'b0, byte_in[5:0], 6'b0};
            default: cont_bits = {15'b0, byte_in[5:0]};
        endcase
        merged = partial_reg | cont_bits;

        if (is_cont)
        begin
            remain_next = remain_reg - 2'd1;
            if (remain_reg == 2'd1)
            begin
                dec.count                   = 2'd1;
                dec.first.code_point        = merged;
                dec.first.last_of_run       = 1'b1;
                partial_next                = '0;
            end
            else
            begin
                partial_next = merged;
            end
        end
        else
        begin
            partial_next = '0;
            remain_next  = 2'd0;
            // Classify the byte on its own
            if (byte_in == 8'h00)
            begin
                own_valid = 1'b1;
                own_eot   = 1'b1;
            end
            else if (byte_in < BYTE_CONT)
            begin
                own_valid = 1'b1;
                own_cp    = {13'b0, byte_in};
            end
            else if (byte_in < BYTE_LEAD2)
            begin
                own_valid = 1'b1;
                own_cp    = CP_REPLACEMENT;
            end
            else if (byte_in < BYTE_LEAD3)
            begin
                partial_next = {10'b0, byte_in[4:0] & MASK_LEAD2[4:0], 6'b0};
                remain_next  = 2'd1;
            end
            else if (byte_in < BYTE_LEAD4)
            begin
                partial_next = {5'b0, byte_in[3:0] & MASK_LEAD3[3:0], 12'b0};
                remain_next  = 2'd2;
            end
            else
            begin
                partial_next = {byte_in[2:0] & MASK_LEAD4[2:0], 18'b0};
                remain_next  = 2'd3;
            end

            // Flush the cut-short partial ahead of the byte's own result
            if (pending)
            begin
                dec.first.code_point  = partial_reg;
                dec.first.last_of_run = !own_valid;
                dec.second.code_point  = own_cp;
                dec.second.end_of_text = own_eot;
                dec.second.last_of_run = 1'b1;
                dec.count = own_valid ? 2'd2 : 2'd1;
            end
            else if (own_valid)
            begin
                dec.first.code_point  = own_cp;
                dec.first.end_of_text = own_eot;
                dec.first.last_of_run = 1'b1;
                dec.count             = 2'd1;
            end
        end
    end

    // Hold the sequence state until a byte is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            remain_reg  <= 2'd0;
        end
        else if (advance)
        begin
            partial_reg <= partial_next;
            remain_reg  <= remain_next;
        end
    end

endmodule

// ----- rtl/ubd_fifo.sv -----
// Result queue taking up to two items per cycle and giving one per cycle while out_ready is high.
module ubd_fifo #(
    parameter int DEPTH = ubd_pkg::FIFO_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  ubd_pkg::result_t push_first,
    input  ubd_pkg::result_t push_second,
    output logic             room_two,
    output logic             out_valid,
    input  logic             out_ready,
    output ubd_pkg::result_t out_item
);
    import ubd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_plus;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign room_two  = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign pop       = out_valid && out_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_plus = ptr_inc(wr_ptr_reg);
        case (push_count)
            2'd1:    wr_ptr_next = wr_ptr_plus;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Write one or two items
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2)
        begin
            mem[wr_ptr_plus] <= push_second;
        end
    end

endmodule

// ----- rtl/utf8_byte_stream_decoder.sv -----
// Lenient UTF-8 decoder: one byte in per cycle while the queue has room, code points out through a result queue.
// A byte accepted into the input register is decoded combinationally and queued once two queue
//   slots are free; its first result is then offered on m_axis from the registered queue.
// Throughput: one byte per cycle and one result per cycle while the queue has room and m_axis is ready, set by
//   the single decode stage; the rare second result of a byte waits in the result queue.
// Reset: rst_n clears the input valid flag, the sequence state and the queue.
module utf8_byte_stream_decoder #(
    parameter int FIFO_DEPTH = ubd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ubd_pkg::TDATA_IN_W-1:0]  s_axis_tdata,   // [7:0] byte_in
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ubd_pkg::TDATA_OUT_W-1:0] m_axis_tdata,   // [20:0] code_point, zero pad
    output logic                            m_axis_tuser,   // [0] end_of_text
    output logic                            m_axis_tlast    // last_of_run
);
    import ubd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       room_two;
    logic       advance;
    logic [1:0] push_count;
    dec_out_t   dec;
    result_t    out_item;

    // Move the held byte into the queue when two slots are free
    assign advance       = in_valid_reg && room_two;
    assign s_axis_tready = !in_valid_reg || advance;
    assign push_count    = advance ? dec.count : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Capture the byte
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    ubd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .byte_in (in_byte_reg),
        .dec     (dec)
    );

    ubd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push_first  (dec.first),
        .push_second (dec.second),
        .room_two    (room_two),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_item    (out_item)
    );

    // Pack the result item
    assign m_axis_tdata = {(TDATA_OUT_W - CP_W)'(0), out_item.code_point};
    assign m_axis_tuser = out_item.end_of_text;
    assign m_axis_tlast = out_item.last_of_run;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the UTF-8 byte stream decoder: stream stimulus and code point check.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ubd_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_BYTES = 1000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;   // [7:0] byte_in
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;        // [20:0] code_point, zero pad
    logic                   m_axis_tuser;        // [0] end_of_text
    logic                   m_axis_tlast;        // last_of_run

    // Decoder state as seen by the predictor
    logic [CP_W-1:0] seq_value = '0;
    logic [1:0]      seq_left = '0;
    result_t         expected_cps [$];

    // Stimulus and receiver controls
    bit  tx_back_to_back = 1'b0;
    bit  rx_calm = 1'b0;
    int  hold_requests = 0;
    int  holds_served = 0;
    int  stall_left = 0;
    int  rx_draw;
    int  quiet_cycles = 0;
    int  mismatches = 0;
    result_t want;

    utf8_byte_stream_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the decoder state by one byte and queue the code points it yields
    function automatic void decode_byte(input logic [7:0] b);
        result_t batch [$];
        result_t r;
        r = '0;
        if (seq_left != 2'd0 && (b & BYTE_CONT_MK) == BYTE_CONT)
        begin
            seq_value = seq_value | (CP_W'(b & MASK_CONT) << (6 * (seq_left - 1)));
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0)
            begin
                r.code_point = seq_value;
                batch.push_back(r);
                seq_value = '0;
            end
        end
        else
        begin
            // A sequence cut short gives up its partial value first
            if (seq_left != 2'd0)
            begin
                r.code_point = seq_value;
                batch.push_back(r);
                seq_value = '0;
                seq_left = 2'd0;
            end
            r = '0;
            if (b == 8'h00)
            begin
                r.end_of_text = 1'b1;
                batch.push_back(r);
            end
            else if (b < BYTE_CONT)
            begin
                r.code_point = CP_W'(b);
                batch.push_back(r);
            end
            else if (b < BYTE_LEAD2)
            begin
                r.code_point = CP_REPLACEMENT;
                batch.push_back(r);
            end
            else if (b < BYTE_LEAD3)
            begin
                seq_value = CP_W'(b & MASK_LEAD2) << 6;
                seq_left = 2'd1;
            end
            else if (b < BYTE_LEAD4)
            begin
                seq_value = CP_W'(b & MASK_LEAD3) << 12;
                seq_left = 2'd2;
            end
            else
            begin
                seq_value = CP_W'(b & MASK_LEAD4) << 18;
                seq_left = 2'd3;
            end
        end
        if (batch.size() != 0)
            batch[batch.size() - 1].last_of_run = 1'b1;
        foreach (batch[i])
            expected_cps.push_back(batch[i]);
    endfunction

    // Offer one byte after a random gap and hold it until accepted
    task automatic push_byte(input logic [7:0] b);
        int gap;
        int draw;
        gap = 0;
        if (!tx_back_to_back)
        begin
            draw = $urandom_range(0, 99);
            if (draw >= 92)
                gap = $urandom_range(5, 30);
            else if (draw >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        decode_byte(b);
    endtask

    // Drop valid and wait until every expected code point has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_cps.size() != 0)
            @(posedge clk);
    endtask

    // Send one unit of text: mostly well-formed sequences, some broken ones and noise
    task automatic send_random_unit(output int sent);
        int kind;
        int len;
        int keep;
        logic [7:0] lead;
        kind = $urandom_range(0, 99);
        sent = 0;
        if (kind < 28)
        begin
            push_byte(8'($urandom_range(1, 127)));
            sent = 1;
        end
        else if (kind < 31)
        begin
            push_byte(8'h00);
            sent = 1;
        end
        else if (kind < 90)
        begin
            len = $urandom_range(2, 4);
            if (len == 2)
                lead = 8'($urandom_range(BYTE_LEAD2, BYTE_LEAD3 - 1));
            else if (len == 3)
                lead = 8'($urandom_range(BYTE_LEAD3, BYTE_LEAD4 - 1));
            else
                lead = 8'($urandom_range(BYTE_LEAD4, 255));
            // Broken sequences stop early and let the next unit cut them off
            keep = (kind < 80) ? len - 1 : $urandom_range(0, len - 2);
            push_byte(lead);
            repeat (keep)
                push_byte(BYTE_CONT | 8'($urandom_range(0, 63)));
            sent = 1 + keep;
        end
        else
        begin
            push_byte(8'($urandom_range(0, 255)));
            sent = 1;
        end
    endtask

    // Field extremes, every byte class and several cut-short sequences
    task automatic test_directed();
        logic [7:0] seq [0:25];
        seq = '{8'h00, 8'h7F, 8'h80, 8'hC1,
                8'hC2, 8'h80, 8'hDF, 8'hBF,
                8'hEF, 8'hBF, 8'hBF,
                8'hF0, 8'h90, 8'h80, 8'h80,
                8'hFF, 8'hBF, 8'hBF, 8'hBF,
                8'hE0, 8'h41,
                8'hF0, 8'h00,
                8'hE1, 8'h80, 8'hC5};
        foreach (seq[i])
            push_byte(seq[i]);
        wait_drained();
    endtask

    // Random text with random gaps on both sides
    task automatic test_random_text();
        int total;
        int n;
        total = 0;
        while (total < RANDOM_BYTES)
        begin
            send_random_unit(n);
            total += n;
        end
        wait_drained();
    endtask

    // Full rate on both sides
    task automatic test_back_to_back();
        int total;
        int n;
        total = 0;
        rx_calm <= 1'b1;
        tx_back_to_back = 1'b1;
        while (total < 200)
        begin
            send_random_unit(n);
            total += n;
        end
        wait_drained();
        tx_back_to_back = 1'b0;
        rx_calm <= 1'b0;
    endtask

    // Hold the receiver off while lead and ASCII byte pairs keep coming, each ASCII byte giving two code points
    task automatic test_backpressure();
        hold_requests <= hold_requests + 1;
        tx_back_to_back = 1'b1;
        @(posedge clk);
        repeat (20)
        begin
            push_byte(8'($urandom_range(BYTE_LEAD2, 255)));
            push_byte(8'($urandom_range(1, 127)));
        end
        wait_drained();
        tx_back_to_back = 1'b0;
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (holds_served != hold_requests)
        begin
            holds_served  <= hold_requests;
            stall_left    <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_calm)
            m_axis_tready <= 1'b1;
        else
        begin
            rx_draw = $urandom_range(0, 99);
            if (rx_draw < 65)
                m_axis_tready <= 1'b1;
            else if (rx_draw < 93)
            begin
                stall_left    <= $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                stall_left    <= $urandom_range(8, 40);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Compare each accepted code point with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_cps.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual cp %h eot %b last %b",
                         $time, m_axis_tdata[CP_W-1:0], m_axis_tuser, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = expected_cps.pop_front();
                if (m_axis_tdata[CP_W-1:0] !== want.code_point)
                begin
                    $display("%0t: code_point mismatch, expected %h, actual %h",
                             $time, want.code_point, m_axis_tdata[CP_W-1:0]);
                    mismatches++;
                end
                if (m_axis_tuser !== want.end_of_text)
                begin
                    $display("%0t: end_of_text mismatch, expected %b, actual %b",
                             $time, want.end_of_text, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last_of_run)
                begin
                    $display("%0t: last_of_run mismatch, expected %b, actual %b",
                             $time, want.last_of_run, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when no item moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_text();
        test_back_to_back();
        test_backpressure();
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
